/* rtl/core/lek_pkg.sv */
// package: shared constants and types of the line editor with erase and kill
package lek_pkg;

  localparam int unsigned LineDepthDef = 32;
  localparam int unsigned CharW        = 8;
  localparam int unsigned CfgIdxW      = 8;

  localparam logic [CharW-1:0] NewlineCode = 8'd10;
  localparam logic [CharW-1:0] EraseReset  = 8'd35;
  localparam logic [CharW-1:0] KillReset   = 8'd64;

  localparam logic [CfgIdxW-1:0] CfgIdxErase = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxKill  = 8'd1;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StEol
  } state_e;

endpackage

/* rtl/core/line_editor_erase_kill_core.sv */
// top level: line editor with erase and kill, line buffer held in a ram
// ordinary, erase and kill requests are accepted one per cycle while idle, with no results
// a newline reads the line out at one character per cycle while the receiver is ready,
// through the registered ram read, then the end-of-line item; input is held off
// reset clears fill count, overflow flag and state, loads erase 35 and kill 64;
// ram contents are undefined and only entries below the fill count are read
module line_editor_erase_kill_core
  import lek_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = LineDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CharW-1:0]   in_char_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CharW-1:0]   out_char_o,
  output logic               end_of_line_o,
  output logic               line_overflowed_o,
  output logic               last_of_run_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CharW-1:0]   cfg_data_i
);

  localparam int unsigned AddrW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(LINE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(LINE_DEPTH);

  state_e state_q, state_d;

  logic [CharW-1:0] erase_q, kill_q;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             ovf_q, ovf_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             rd_pend_q, rd_pend_d;

  logic             in_acc, out_acc;
  logic             is_nl, is_erase, is_kill;
  logic             ram_we, ram_re;
  logic             rd_more;
  logic [CharW-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_q <= EraseReset;
      kill_q  <= KillReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxErase) begin
        erase_q <= cfg_data_i;
      end else if (cfg_index_i == CfgIdxKill) begin
        kill_q <= cfg_data_i;
      end
    end
  end

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_acc  = out_valid_o && out_ready_i;
  assign is_nl    = (in_char_i == NewlineCode);
  assign is_erase = !is_nl && (in_char_i == erase_q);
  assign is_kill  = !is_nl && !is_erase && (in_char_i == kill_q);
  assign rd_more  = (rd_idx_q < fill_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && is_nl) begin
          state_d = StRead;
        end
      end
      StRead: begin
        if (!rd_more && (!rd_pend_q || out_ready_i)) begin
          state_d = StEol;
        end
      end
      StEol: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs and ram control
  always_comb begin
    in_ready_o        = 1'b0;
    out_valid_o       = 1'b0;
    out_char_o        = ram_rdata;
    end_of_line_o     = 1'b0;
    line_overflowed_o = 1'b0;
    last_of_run_o     = 1'b0;
    ram_re            = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
      end
      StRead: begin
        out_valid_o = rd_pend_q;
        ram_re      = rd_more && (!rd_pend_q || out_ready_i);
      end
      StEol: begin
        out_valid_o       = 1'b1;
        out_char_o        = NewlineCode;
        end_of_line_o     = 1'b1;
        line_overflowed_o = ovf_q;
        last_of_run_o     = 1'b1;
      end
      default: ;
    endcase
  end

  // line state update; writes happen only in idle, reads only in readout
  always_comb begin
    fill_d    = fill_q;
    ovf_d     = ovf_q;
    ram_we    = 1'b0;
    rd_idx_d  = rd_idx_q;
    rd_pend_d = rd_pend_q;
    if (in_acc) begin
      priority if (is_nl) begin
        rd_idx_d  = '0;
        rd_pend_d = 1'b0;
      end else if (is_erase) begin
        if (fill_q != '0) begin
          fill_d = fill_q - CntW'(1);
        end
      end else if (is_kill) begin
        fill_d = '0;
        ovf_d  = 1'b0;
      end else if (fill_q < DepthCnt) begin
        ram_we = 1'b1;
        fill_d = fill_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (state_q == StRead) begin
      if (ram_re) begin
        rd_idx_d  = rd_idx_q + CntW'(1);
        rd_pend_d = 1'b1;
      end else if (out_ready_i) begin
        rd_pend_d = 1'b0;
      end
    end
    if (state_q == StEol && out_acc) begin
      fill_d = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      ovf_q     <= 1'b0;
      rd_idx_q  <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      ovf_q     <= ovf_d;
      rd_idx_q  <= rd_idx_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  lek_ram #(
    .Width (CharW),
    .Depth (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AddrW-1:0]),
    .wdata_i (in_char_i),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

endmodule

/* rtl/core/lek_ram.sv */
// generic simple dual-port ram with registered read
module lek_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/lek_checker.sv */
// checker: port-level assertions for the line editor, bound to the top level
module lek_checker
  import lek_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [CharW-1:0]   out_char_o,
  input logic               end_of_line_o,
  input logic               line_overflowed_o,
  input logic               last_of_run_o
);

  // output request holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output request dropped before it was taken");

  // no input taken while a line is being read out
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready during line readout");

  // end-of-line item is a newline and closes the run
  a_eol_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_line_o |-> last_of_run_o && (out_char_o == NewlineCode))
    else $error("malformed end-of-line item");

  // character items carry no overflow flag and never close the run
  a_char_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_line_o |-> !line_overflowed_o && !last_of_run_o)
    else $error("malformed character item");

  // input reopens right after the end-of-line item is taken
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_of_run_o |=> in_ready_o)
    else $error("input not ready after end of line");

endmodule

bind line_editor_erase_kill_core lek_checker u_lek_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .out_char_o        (out_char_o),
  .end_of_line_o     (end_of_line_o),
  .line_overflowed_o (line_overflowed_o),
  .last_of_run_o     (last_of_run_o)
);

/* sim/tb_line_editor_erase_kill_core.sv */
// testbench: line editor with erase and kill, checked against a line model
module tb_line_editor_erase_kill_core
  import lek_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LineDepth = LineDepthDef;
  localparam int HoldCycles = 300;
  localparam int IdleLimit  = 3000;
  localparam int DrainWait  = 4;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             eol;
    logic             ovf;
    logic             last;
  } line_item_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [CharW-1:0]   in_char_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [CharW-1:0]   out_char_o;
  logic               end_of_line_o;
  logic               line_overflowed_o;
  logic               last_of_run_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CharW-1:0]   cfg_data_i  = '0;

  logic [CharW-1:0] pending_chars[$];
  line_item_t       expected_line_out[$];

  // line model state
  logic [CharW-1:0] erase_code = EraseReset;
  logic [CharW-1:0] kill_code  = KillReset;
  logic [CharW-1:0] line_chars[LineDepth];
  int unsigned      line_fill    = 0;
  logic             line_dropped = 1'b0;

  // stimulus side view of the control codes
  logic [CharW-1:0] gen_erase = EraseReset;
  logic [CharW-1:0] gen_kill  = KillReset;

  int failures      = 0;
  int idle_cycles   = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int burst_left    = 0;
  int gap_left      = 0;
  int pattern_left  = 0;
  logic [15:0] stall_pattern = '1;

  line_editor_erase_kill_core #(
    .LINE_DEPTH(LineDepth)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_char_i,
    .out_valid_o,
    .out_ready_i,
    .out_char_o,
    .end_of_line_o,
    .line_overflowed_o,
    .last_of_run_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  function automatic void predict_line_edit(input logic [CharW-1:0] c);
    line_item_t r;
    if (c == NewlineCode) begin
      for (int i = 0; i < int'(line_fill); i++) begin
        r = '{ch: line_chars[i], eol: 1'b0, ovf: 1'b0, last: 1'b0};
        expected_line_out.push_back(r);
      end
      r = '{ch: NewlineCode, eol: 1'b1, ovf: line_dropped, last: 1'b1};
      expected_line_out.push_back(r);
      line_fill    = 0;
      line_dropped = 1'b0;
    end else if (c == erase_code) begin
      if (line_fill > 0) line_fill--;
    end else if (c == kill_code) begin
      line_fill    = 0;
      line_dropped = 1'b0;
    end else if (line_fill < LineDepth) begin
      line_chars[line_fill] = c;
      line_fill++;
    end else begin
      line_dropped = 1'b1;
    end
  endfunction

  function automatic void apply_register(input logic [CfgIdxW-1:0] idx,
                                         input logic [CharW-1:0] val);
    if (idx == CfgIdxErase) erase_code = val;
    else if (idx == CfgIdxKill) kill_code = val;
  endfunction

  // driver: bursts of requests with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    bit take;
    bit present;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_char_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      take    = in_valid_i && in_ready_o;
      present = 1'b0;
      if (take) pending_chars.delete(0);
      if (in_valid_i && !take) begin
        present = 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_chars.size() != 0) begin
        present = 1'b1;
        in_char_i <= pending_chars[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      in_valid_i <= present;
    end
  end

  // receiver: rotating stall pattern, plus long holds on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready_i <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left   <= HoldCycles;
    end else if (pattern_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pattern <= '1;
        1: stall_pattern <= 16'($urandom);
        2: stall_pattern <= 16'($urandom | $urandom);
        default: stall_pattern <= 16'($urandom & $urandom);
      endcase
      pattern_left <= 48;
      out_ready_i  <= 1'b1;
    end else begin
      out_ready_i   <= stall_pattern[0];
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      pattern_left  <= pattern_left - 1;
    end
  end

  // monitor: prediction on accepted requests, checking on accepted results
  always @(posedge clk_i) begin
    line_item_t want;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        apply_register(cfg_index_i, cfg_data_i);
        moved = 1'b1;
      end
      if (in_valid_i && in_ready_o) begin
        predict_line_edit(in_char_i);
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (expected_line_out.size() == 0) begin
          $error("unexpected result: out_char %0d end_of_line %0b", out_char_o,
                 end_of_line_o);
          failures++;
        end else begin
          want = expected_line_out.pop_front();
          if (out_char_o !== want.ch) begin
            $error("out_char: expected %0d, got %0d", want.ch, out_char_o);
            failures++;
          end
          if (end_of_line_o !== want.eol) begin
            $error("end_of_line: expected %0b, got %0b", want.eol, end_of_line_o);
            failures++;
          end
          if (line_overflowed_o !== want.ovf) begin
            $error("line_overflowed: expected %0b, got %0b", want.ovf,
                   line_overflowed_o);
            failures++;
          end
          if (last_of_run_o !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, last_of_run_o);
            failures++;
          end
        end
      end
      if (moved) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("timeout: no handshake for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_chars.size() != 0 || in_valid_i || expected_line_out.size() != 0);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CharW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_controls(input logic [CharW-1:0] e, input logic [CharW-1:0] k);
    wait_drained();
    write_register(CfgIdxErase, e);
    write_register(CfgIdxKill, k);
    gen_erase = e;
    gen_kill  = k;
  endtask

  function automatic logic [CharW-1:0] plain_char();
    logic [CharW-1:0] c;
    do c = CharW'($urandom_range(0, 255));
    while (c == NewlineCode);
    return c;
  endfunction

  // a well-formed line: characters with some erase and kill codes, then newline
  task automatic queue_line(input int len, inout int count);
    int pick;
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) pending_chars.push_back(gen_erase);
      else if (pick == 2 && $urandom_range(0, 2) == 0) pending_chars.push_back(gen_kill);
      else pending_chars.push_back(plain_char());
    end
    pending_chars.push_back(NewlineCode);
    count += len + 1;
  endtask

  task automatic queue_random(input int target);
    int count;
    int len;
    count = 0;
    while (count < target) begin
      if ($urandom_range(0, 5) == 0) begin
        len = $urandom_range(1, 4);
        repeat (len) pending_chars.push_back(CharW'($urandom_range(0, 255)));
        count += len;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
        queue_line(len, count);
      end
    end
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset codes: empty line, erase on empty, erase, kill, bit patterns
    pending_chars = '{NewlineCode, EraseReset,
                      8'h00, 8'hFF, 8'h61, EraseReset, NewlineCode,
                      8'h78, 8'h79, KillReset, 8'h7A, NewlineCode,
                      8'h7F, 8'h80, 8'h55, 8'hAA, 8'h01, NewlineCode};
    queue_random(25);

    set_controls(8'h00, 8'hFF);
    queue_random(15);

    // same code for both acts as erase
    set_controls(8'h7F, 8'h7F);
    queue_random(15);

    // newline wins over both controls; writes beyond the last register do nothing
    set_controls(NewlineCode, NewlineCode);
    write_register(8'd2, 8'h23);
    write_register(8'hFF, 8'h40);
    queue_random(12);

    // long receiver hold with full and overflowing lines queued behind it
    set_controls(8'hFF, 8'h00);
    hold_requests++;
    n = 0;
    queue_line(36, n);
    repeat (35) pending_chars.push_back(plain_char());
    pending_chars.push_back(gen_kill);
    pending_chars.push_back(8'h41);
    pending_chars.push_back(NewlineCode);
    repeat (LineDepth) pending_chars.push_back(plain_char());
    pending_chars.push_back(NewlineCode);
    repeat (34) pending_chars.push_back(plain_char());
    pending_chars.push_back(gen_erase);
    pending_chars.push_back(NewlineCode);
    queue_random(12);

    set_controls(EraseReset, KillReset);
    queue_random(15);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (expected_line_out.size() != 0) begin
      $error("%0d expected results never arrived", expected_line_out.size());
      failures++;
    end
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
